// File: hdl/bmpru_pkg.sv
package bmpru_pkg;

    // Default sizes, overridable at the top level
    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int MAX_HEIGHT_DEF    = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Output coordinate width
    localparam int COORD_W = 12;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Input command codes
    localparam logic CMD_PAL_WRITE = 1'b0;
    localparam logic CMD_PIXEL     = 1'b1;

    typedef enum logic [1:0] {
        FMT_1BPP  = 2'd0,
        FMT_4BPP  = 2'd1,
        FMT_8BPP  = 2'd2,
        FMT_24BPP = 2'd3
    } fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_FORMAT = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } reg_idx_t;

    typedef enum logic {
        JOB_PAL_WRITE = 1'b0,
        JOB_PIXELS    = 1'b1
    } job_kind_t;

    // One classified beat. Palette write: data = index, color = entry.
    // Pixels: data = raw byte (palette formats), color = RGB (24 bpp).
    typedef struct packed {
        job_kind_t          kind;
        fmt_t               fmt;
        logic [7:0]         data;
        logic [23:0]        color;
        logic [COORD_W-1:0] x0;
        logic [3:0]         count;
        logic [COORD_W-1:0] row;
        logic               done;
    } job_t;

endpackage

// File: hdl/bmpru_if.sv
interface bmpru_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
    logic [7:0]  data_byte;

    modport source (output valid, command, palette_index, palette_color, data_byte,
                    input ready);
    modport sink (input valid, command, palette_index, palette_color, data_byte,
                  output ready);
endinterface

interface bmpru_out_if;
    import bmpru_pkg::*;
    logic               valid;
    logic               ready;
    logic [31:0]        pixel_color;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_row;
    logic               last_of_run;
    logic               image_done;

    modport source (output valid, pixel_color, dest_x, dest_row, last_of_run, image_done,
                    input ready);
    modport sink (input valid, pixel_color, dest_x, dest_row, last_of_run, image_done,
                  output ready);
endinterface

interface bmpru_cfg_if;
    import bmpru_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/bmpru_front.sv
module bmpru_front #(
    parameter int MAX_WIDTH  = bmpru_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmpru_pkg::MAX_HEIGHT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    bmpru_cfg_if.sink        cfg,
    bmpru_in_if.sink         din,
    input  logic             q_full,
    output logic             q_push,
    output bmpru_pkg::job_t  q_job
);
    import bmpru_pkg::*;

    localparam int WD_W    = $clog2(MAX_WIDTH + 1);
    localparam int HT_W    = $clog2(MAX_HEIGHT + 1);
    localparam int MAX_BPL = ((MAX_WIDTH * 3 + 3) / 4) * 4;
    localparam int BIR_W   = $clog2(MAX_BPL + 1);
    localparam int RB_W    = BIR_W + 1;
    localparam int XW      = BIR_W + 3;
    localparam int WCMP_W  = (WD_W > CFG_DATA_W) ? WD_W : CFG_DATA_W;
    localparam int HCMP_W  = (HT_W > CFG_DATA_W) ? HT_W : CFG_DATA_W;
    // divide by 3 through a reciprocal, exact below 2**BIR_W
    localparam int DIV_S   = BIR_W + 2;
    localparam int DIV_M_W = BIR_W + 1;
    localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(((1 << DIV_S) + 2) / 3);
    localparam int PROD_W  = BIR_W + DIV_M_W;

    fmt_t              fmt_reg;
    logic [CFG_DATA_W-1:0] width_reg, height_reg;
    logic [BIR_W-1:0]  bir_reg, bir_next;
    logic [HT_W-1:0]   row_reg, row_next;
    logic [15:0]       partial_reg, partial_next;
    logic              fin_reg, fin_next;

    logic [WD_W-1:0]   w_eff;
    logic [HT_W-1:0]   h_eff;
    logic [RB_W-1:0]   raw_bytes, bpl, bir_inc;
    logic              row_end, img_over, last_row, accept;
    logic [HT_W-1:0]   row_inc;
    logic [COORD_W-1:0] dest_row;
    logic [PROD_W-1:0] prod;
    logic [BIR_W-1:0]  quo;
    logic [1:0]        comp;
    logic              x24_in, x24_last;
    logic [1:0]        sh;
    logic [3:0]        per, n_pix;
    logic [XW-1:0]     x0, rem;
    logic              in_row, pal_done;

    assign cfg.ready = 1'b1;
    assign din.ready = !q_full;
    assign accept    = din.valid && din.ready;

    // effective dimensions: zero reads as one, saturate at the maximum
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WD_W'(1);
        else if (WCMP_W'(width_reg) > WCMP_W'(MAX_WIDTH))
            w_eff = WD_W'(MAX_WIDTH);
        else
            w_eff = WD_W'(width_reg);

        if (height_reg == '0)
            h_eff = HT_W'(1);
        else if (HCMP_W'(height_reg) > HCMP_W'(MAX_HEIGHT))
            h_eff = HT_W'(MAX_HEIGHT);
        else
            h_eff = HT_W'(height_reg);
    end

    // row length in bytes, padded to four
    always_comb
    begin
        unique case (fmt_reg)
            FMT_1BPP:  raw_bytes = (RB_W'(w_eff) + RB_W'(7)) >> 3;
            FMT_4BPP:  raw_bytes = (RB_W'(w_eff) + RB_W'(1)) >> 1;
            FMT_8BPP:  raw_bytes = RB_W'(w_eff);
            FMT_24BPP: raw_bytes = (RB_W'(w_eff) << 1) + RB_W'(w_eff);
            default:   raw_bytes = RB_W'(w_eff);
        endcase
        bpl = (raw_bytes + RB_W'(3)) & ~RB_W'(3);
    end

    assign bir_inc  = RB_W'(bir_reg) + RB_W'(1);
    assign row_end  = (bir_inc >= bpl);
    assign row_inc  = row_reg + HT_W'(1);
    assign img_over = fin_reg || (row_reg >= h_eff);
    assign last_row = (row_reg == h_eff - HT_W'(1));
    assign dest_row = COORD_W'(h_eff - HT_W'(1) - row_reg);

    // 24 bpp: pixel = byte / 3, component = byte % 3
    assign prod     = PROD_W'(bir_reg) * PROD_W'(DIV_M);
    assign quo      = BIR_W'(prod >> DIV_S);
    assign comp     = 2'(bir_reg - ((quo << 1) + quo));
    assign x24_in   = XW'(quo) < XW'(w_eff);
    assign x24_last = XW'(quo) == (XW'(w_eff) - XW'(1));

    // palette formats
    always_comb
    begin
        unique case (fmt_reg)
            FMT_1BPP:  begin sh = 2'd3; per = 4'd8; end
            FMT_4BPP:  begin sh = 2'd1; per = 4'd2; end
            FMT_8BPP:  begin sh = 2'd0; per = 4'd1; end
            FMT_24BPP: begin sh = 2'd0; per = 4'd1; end
            default:   begin sh = 2'd0; per = 4'd1; end
        endcase
    end

    assign x0       = XW'(bir_reg) << sh;
    assign in_row   = x0 < XW'(w_eff);
    assign rem      = XW'(w_eff) - x0;
    assign n_pix    = (rem >= XW'(per)) ? per : rem[3:0];
    assign pal_done = last_row && (rem <= XW'(per));

    // job build
    always_comb
    begin
        q_job       = '0;
        q_job.fmt   = fmt_reg;
        q_job.row   = dest_row;
        q_push      = 1'b0;
        if (din.command == CMD_PAL_WRITE)
        begin
            q_job.kind  = JOB_PAL_WRITE;
            q_job.data  = din.palette_index;
            q_job.color = din.palette_color;
            q_push      = accept;
        end
        else if (fmt_reg == FMT_24BPP)
        begin
            q_job.kind  = JOB_PIXELS;
            q_job.color = {din.data_byte, partial_reg};
            q_job.x0    = COORD_W'(quo);
            q_job.count = 4'd1;
            q_job.done  = last_row && x24_last;
            q_push      = accept && !img_over && x24_in && (comp == 2'd2);
        end
        else
        begin
            q_job.kind  = JOB_PIXELS;
            q_job.data  = din.data_byte;
            q_job.x0    = COORD_W'(x0);
            q_job.count = n_pix;
            q_job.done  = pal_done;
            q_push      = accept && !img_over && in_row;
        end
    end

    // position state
    always_comb
    begin
        bir_next     = bir_reg;
        row_next     = row_reg;
        partial_next = partial_reg;
        fin_next     = fin_reg;
        if (accept && din.command == CMD_PIXEL)
        begin
            if (img_over)
                fin_next = 1'b1;
            else
            begin
                if (fmt_reg == FMT_24BPP && x24_in)
                begin
                    if (comp == 2'd0)
                        partial_next = {8'h00, din.data_byte};
                    else if (comp == 2'd1)
                        partial_next = {din.data_byte, partial_reg[7:0]};
                end
                if (row_end)
                begin
                    bir_next     = '0;
                    partial_next = '0;
                    row_next     = row_inc;
                    if (row_inc >= h_eff)
                        fin_next = 1'b1;
                end
                else
                    bir_next = bir_inc[BIR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg     <= FMT_24BPP;
            width_reg   <= CFG_DATA_W'(1);
            height_reg  <= CFG_DATA_W'(1);
            bir_reg     <= '0;
            row_reg     <= '0;
            partial_reg <= '0;
            fin_reg     <= 1'b0;
        end
        else
        begin
            bir_reg     <= bir_next;
            row_reg     <= row_next;
            partial_reg <= partial_next;
            fin_reg     <= fin_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_PIXEL_FORMAT: fmt_reg    <= fmt_t'(cfg.data[1:0]);
                    REG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                    default:          ;
                endcase
            end
        end
    end

endmodule

// File: hdl/bmpru_queue.sv
module bmpru_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bmpru_pkg::job_t  push_job,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output bmpru_pkg::job_t  head
);
    import bmpru_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          slot_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// File: hdl/bmpru_back.sv
module bmpru_back #(
    parameter int PALETTE_DEPTH = bmpru_pkg::PALETTE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  bmpru_pkg::job_t  head,
    output logic             pop,
    bmpru_out_if.source      dout
);
    import bmpru_pkg::*;

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    logic [23:0]        pal_mem [PALETTE_DEPTH];

    logic [2:0]         k_reg, k_next;
    logic               out_valid_reg, out_valid_next;
    logic [23:0]        rd_data_reg;
    logic [23:0]        direct_reg;
    logic               direct_sel_reg, zero_sel_reg;
    logic [COORD_W-1:0] x_reg, row_reg;
    logic               last_reg, done_reg;

    logic               pal_wr, issue, last_k, wr_in_range, rd_in_range;
    logic [7:0]         pal_idx;
    logic [PAL_AW-1:0]  rd_addr;

    assign pal_wr      = head_valid && (head.kind == JOB_PAL_WRITE);
    assign issue       = head_valid && (head.kind == JOB_PIXELS)
                         && (!out_valid_reg || dout.ready);
    assign last_k      = ({1'b0, k_reg} == head.count - 4'd1);
    assign pop         = pal_wr || (issue && last_k);
    assign wr_in_range = {1'b0, head.data} < 9'(PALETTE_DEPTH);

    // palette index of pixel k, most significant pixel first
    always_comb
    begin
        unique case (head.fmt)
            FMT_1BPP:  pal_idx = {7'd0, head.data[3'd7 - k_reg]};
            FMT_4BPP:  pal_idx = k_reg[0] ? {4'd0, head.data[3:0]} : {4'd0, head.data[7:4]};
            FMT_8BPP:  pal_idx = head.data;
            FMT_24BPP: pal_idx = head.data;
            default:   pal_idx = head.data;
        endcase
    end

    assign rd_in_range = {1'b0, pal_idx} < 9'(PALETTE_DEPTH);
    assign rd_addr     = pal_idx[PAL_AW-1:0];

    always_comb
    begin
        k_next = k_reg;
        if (issue)
            k_next = last_k ? '0 : k_reg + 3'd1;
        out_valid_next = out_valid_reg;
        if (issue)
            out_valid_next = 1'b1;
        else if (dout.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // palette RAM, one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (pal_wr && wr_in_range)
            pal_mem[head.data[PAL_AW-1:0]] <= head.color;
        if (issue)
            rd_data_reg <= pal_mem[rd_addr];
    end

    // output stage payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            direct_reg     <= head.color;
            direct_sel_reg <= (head.fmt == FMT_24BPP);
            zero_sel_reg   <= !rd_in_range;
            x_reg          <= head.x0 + COORD_W'(k_reg);
            row_reg        <= head.row;
            last_reg       <= last_k;
            done_reg       <= last_k && head.done;
        end
    end

    assign dout.valid       = out_valid_reg;
    assign dout.pixel_color = {ALPHA_OPAQUE,
                               direct_sel_reg ? direct_reg :
                               (zero_sel_reg ? 24'd0 : rd_data_reg)};
    assign dout.dest_x      = x_reg;
    assign dout.dest_row    = row_reg;
    assign dout.last_of_run = last_reg;
    assign dout.image_done  = done_reg;

    a_issue_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> ({1'b0, k_reg} < head.count))
        else $error("pixel issued past end of job");

    a_palwr_between_jobs: assert property (@(posedge clk) disable iff (!rst_n)
        pal_wr |-> (k_reg == '0))
        else $error("palette write inside a pixel run");

    a_last_marks_run: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && last_k) |=> (out_valid_reg && last_reg))
        else $error("end of run not flagged");

endmodule

// File: hdl/bmp_row_pixel_unpacker_unit.sv
// Channel  Dir  Beat                                               Accepted on
// -------  ---  -------------------------------------------------  -----------------
// cfg      in   index, data (format / width / height)              cfg.valid & ready
// din      in   command, palette_index, palette_color, data_byte   din.valid & ready
// dout     out  pixel_color, dest_x, dest_row, last_of_run, done   dout.valid & ready
//
// Throughput: the front takes one input beat per cycle while the 4-entry job queue
// has room; the back drives one pixel per cycle from the palette RAM read port while
// dout accepts it. A data byte makes up to 8 pixels at 1 bpp, 2 at 4 bpp, 1 at 8 bpp;
// at 24 bpp three bytes make one pixel. Palette writes are popped with no output.
// With an idle queue a byte goes through a queue slot and the output register to dout.
// Reset: counters cleared, format 24 bpp, width and height 1; palette RAM holds
// garbage until written, no clear pass. Output stalls hold the output register
// and back up into the queue, then din.ready drops; cfg.ready is always high.
module bmp_row_pixel_unpacker_unit #(
    parameter int MAX_WIDTH     = bmpru_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = bmpru_pkg::MAX_HEIGHT_DEF,
    parameter int PALETTE_DEPTH = bmpru_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bmpru_cfg_if.sink   cfg,
    bmpru_in_if.sink    din,
    bmpru_out_if.source dout
);
    import bmpru_pkg::*;

    // front -> queue
    logic q_push, q_full;
    job_t q_job;

    // queue -> back
    logic q_pop, q_head_valid;
    job_t q_head;

    // Front: config registers, row / column bookkeeping, padding and
    // end-of-image filtering; turns each beat into at most one job.
    bmpru_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .din    (din),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (q_job)
    );

    // Short job queue so the input side keeps moving during pixel bursts.
    bmpru_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // Back: palette RAM, per-pixel expansion, output register.
    // Palette writes pass through the queue so they stay ordered with lookups.
    bmpru_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .dout       (dout)
    );

endmodule

// File: test/bmp_row_pixel_unpacker_unit_tb.sv
`timescale 1ns / 1ps

module bmp_row_pixel_unpacker_unit_tb;
    import bmpru_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 8;
    // Quiet cycles (no beat on any channel) before the run is declared hung.
    // Worst honest gap: the long output hold-off plus a few idle draws.
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    // Idle spacing after the last pixel: covers queued palette writes and
    // padding bytes that are still draining through the 4-deep job queue.
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_BEATS = 300;
    localparam int MAX_PHASE_BYTES = 40;

    // One output pixel as seen on dout
    typedef struct {
        logic [31:0]        color;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] row;
        logic               last;
        logic               done;
    } pixel_t;

    // Scoreboard: tracks palette, row position and config, and queues the
    // pixels each accepted input beat should produce.
    class bmp_pixel_predictor;
        logic [23:0] palette [256];
        bit          written [256];
        int          byte_in_row;
        int          source_row;
        logic [15:0] partial_bg;
        bit          finished;
        fmt_t        fmt;
        logic [12:0] width_reg;
        logic [12:0] height_reg;
        pixel_t      pending_pixels [$];
        int          errors;
        int          pixels_checked;

        function new();
            byte_in_row    = 0;
            source_row     = 0;
            partial_bg     = '0;
            finished       = 1'b0;
            fmt            = FMT_24BPP;
            width_reg      = 13'd1;
            height_reg     = 13'd1;
            errors         = 0;
            pixels_checked = 0;
        endfunction

        task report(input string msg);
            errors++;
            // keep the log readable if the block goes badly wrong
            if (errors <= 50)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function void set_register(input reg_idx_t r, input logic [12:0] d);
            case (r)
                REG_PIXEL_FORMAT: fmt = fmt_t'(d[1:0]);
                REG_IMAGE_WIDTH:  width_reg = d;
                REG_IMAGE_HEIGHT: height_reg = d;
                default: ;
            endcase
        endfunction

        function int eff_dim(input logic [12:0] v, input int max_v);
            if (v == 0)
                return 1;
            return (int'(v) > max_v) ? max_v : int'(v);
        endfunction

        function int bits_per_pixel();
            case (fmt)
                FMT_1BPP: return 1;
                FMT_4BPP: return 4;
                default:  return 8;
            endcase
        endfunction

        // Stored row length in bytes, padded to a multiple of four
        function int row_len();
            int w;
            int raw;
            w = eff_dim(width_reg, MAX_WIDTH_DEF);
            case (fmt)
                FMT_1BPP: raw = (w + 7) / 8;
                FMT_4BPP: raw = (w + 1) / 2;
                FMT_8BPP: raw = w;
                default:  raw = w * 3;
            endcase
            return (raw + 3) / 4 * 4;
        endfunction

        function int bytes_left();
            int n;
            n = row_len() - byte_in_row;
            return (n < 1) ? 1 : n;
        endfunction

        // True when a data byte would only look up palette entries already loaded
        function bit reads_known(input logic [7:0] b);
            int w;
            int h;
            int bpp;
            int per;
            int x;
            int v;
            w = eff_dim(width_reg, MAX_WIDTH_DEF);
            h = eff_dim(height_reg, MAX_HEIGHT_DEF);
            if (finished || source_row >= h || fmt == FMT_24BPP)
                return 1'b1;
            bpp = bits_per_pixel();
            per = 8 / bpp;
            for (int k = 0; k < per; k++) begin
                x = byte_in_row * per + k;
                if (x >= w)
                    break;
                v = (int'(b) >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
                if (!written[v])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function pixel_t make_pixel(input logic [23:0] rgb, input int x, input int w,
                                    input int h);
            pixel_t p;
            p.color = {ALPHA_OPAQUE, rgb};
            p.x     = COORD_W'(x);
            p.row   = COORD_W'(h - 1 - source_row);
            p.last  = 1'b0;
            p.done  = (x == w - 1) && (source_row == h - 1);
            return p;
        endfunction

        function int note_beat(input logic cmd, input logic [7:0] idx,
                               input logic [23:0] color, input logic [7:0] b);
            int     w;
            int     h;
            int     bpp;
            int     per;
            int     x;
            int     v;
            pixel_t run [$];
            if (cmd == CMD_PAL_WRITE) begin
                palette[idx] = color;
                written[idx] = 1'b1;
                return 0;
            end
            w = eff_dim(width_reg, MAX_WIDTH_DEF);
            h = eff_dim(height_reg, MAX_HEIGHT_DEF);
            // past the last row: swallowed until reset
            if (finished || source_row >= h) begin
                finished = 1'b1;
                return 0;
            end
            if (fmt == FMT_24BPP) begin
                x = byte_in_row / 3;
                if (x < w) begin
                    case (byte_in_row % 3)
                        0: partial_bg = {8'h00, b};
                        1: partial_bg[15:8] = b;
                        default: run.push_back(make_pixel({b, partial_bg}, x, w, h));
                    endcase
                end
            end else begin
                bpp = bits_per_pixel();
                per = 8 / bpp;
                for (int k = 0; k < per; k++) begin
                    x = byte_in_row * per + k;
                    if (x >= w)
                        break;
                    v = (int'(b) >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
                    run.push_back(make_pixel(palette[v], x, w, h));
                end
            end
            if (run.size() > 0)
                run[run.size() - 1].last = 1'b1;
            foreach (run[i])
                pending_pixels.push_back(run[i]);
            byte_in_row++;
            if (byte_in_row >= row_len()) begin
                byte_in_row = 0;
                partial_bg  = '0;
                source_row++;
                if (source_row >= h)
                    finished = 1'b1;
            end
            return run.size();
        endfunction

        task check_pixel(input pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0) begin
                report($sformatf("unexpected pixel %h at x=%0d row=%0d",
                                 got.color, got.x, got.row));
                return;
            end
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got.color !== want.color)
                report($sformatf("pixel_color %h, want %h (x=%0d row=%0d)",
                                 got.color, want.color, want.x, want.row));
            if (got.x !== want.x)
                report($sformatf("dest_x %0d, want %0d", got.x, want.x));
            if (got.row !== want.row)
                report($sformatf("dest_row %0d, want %0d", got.row, want.row));
            if (got.last !== want.last)
                report($sformatf("last_of_run %b, want %b (x=%0d row=%0d)",
                                 got.last, want.last, want.x, want.row));
            if (got.done !== want.done)
                report($sformatf("image_done %b, want %b (x=%0d row=%0d)",
                                 got.done, want.done, want.x, want.row));
        endtask
    endclass

    logic clk;
    logic rst_n;

    bmpru_cfg_if cfg_ch ();
    bmpru_in_if  din_ch ();
    bmpru_out_if dout_ch ();

    bmp_row_pixel_unpacker_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .din   (din_ch),
        .dout  (dout_ch)
    );

    bmp_pixel_predictor pixel_pred;

    // Shared state for the stimulus, the pixel sink and the hang detector
    bit hold_request;
    bit hold_done;
    bit tx_idle_on;
    bit rx_idle_on;
    bit done_seen;
    int palette_writes;
    int data_bytes;
    int phase_count;
    int quiet_cycles;

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Input side. Every task is entered just after a rising edge and
    // returns just after the edge on which its beat was accepted.
    // ---------------------------------------------------------------

    task automatic send_beat(input logic cmd, input logic [7:0] idx,
                             input logic [23:0] color, input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            din_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_ch.valid         <= 1'b1;
        din_ch.command       <= cmd;
        din_ch.palette_index <= idx;
        din_ch.palette_color <= color;
        din_ch.data_byte     <= b;
        do @(posedge clk); while (din_ch.ready !== 1'b1);
        void'(pixel_pred.note_beat(cmd, idx, color, b));
        if (cmd == CMD_PAL_WRITE)
            palette_writes++;
        else
            data_bytes++;
    endtask

    // Pixel byte; the unused palette fields carry noise
    task automatic send_byte(input logic [7:0] b);
        send_beat(CMD_PIXEL, 8'($urandom), 24'($urandom), b);
    endtask

    task automatic send_palette_entry();
        logic [7:0] idx;
        // half the writes land in the low 16 entries that 1 and 4 bpp use
        idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
        send_beat(CMD_PAL_WRITE, idx, 24'($urandom), 8'($urandom));
    endtask

    // Random byte, redrawn until every palette entry it selects is loaded
    task automatic send_row_byte();
        logic [7:0] b;
        b = 8'($urandom);
        while (!pixel_pred.reads_known(b))
            b = 8'($urandom);
        send_byte(b);
    endtask

    // Leaves cfg valid high so back-to-back writes need no toggle;
    // the caller drops it after the last one.
    task automatic write_register(input reg_idx_t r, input logic [12:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= d;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        pixel_pred.set_register(r, d);
    endtask

    // Stop offering, let every expected pixel arrive, then let the queue
    // drain any beats that make no pixels before touching the registers.
    task automatic settle();
        din_ch.valid <= 1'b0;
        while (pixel_pred.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        phase_count++;
    endtask

    // ---------------------------------------------------------------
    // Output side: random ready with occasional runs of full rate, and
    // one long hold-off on request so the job queue fills and din stalls.
    // ---------------------------------------------------------------
    initial begin
        int     gap;
        int     rx_count;
        pixel_t got;
        rx_count = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request && !hold_done) begin
                dout_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                gap = rx_idle_on ? $urandom_range(0, 11) : 0;
                if (gap > 0) begin
                    dout_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            dout_ch.ready <= 1'b1;
            do @(posedge clk); while (dout_ch.valid !== 1'b1);
            got.color = dout_ch.pixel_color;
            got.x     = dout_ch.dest_x;
            got.row   = dout_ch.dest_row;
            got.last  = dout_ch.last_of_run;
            got.done  = dout_ch.image_done;
            if (got.done === 1'b1)
                done_seen = 1'b1;
            pixel_pred.check_pixel(got);
            rx_count++;
            if (rx_count % 32 == 0)
                rx_idle_on = ($urandom_range(0, 3) != 0);
        end
    end

    // Hang detector: any beat on any channel resets the count
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if ((din_ch.valid & din_ch.ready) === 1'b1 ||
                (dout_ch.valid & dout_ch.ready) === 1'b1 ||
                (cfg_ch.valid & cfg_ch.ready) === 1'b1)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat for %0d cycles, %0d pixels outstanding",
                         quiet_cycles, pixel_pred.pending_pixels.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        int          random_beats;
        int          n;
        int          pick;
        logic [12:0] dim;

        pixel_pred     = new();
        random_beats   = 0;
        palette_writes = 0;
        data_bytes     = 0;
        phase_count    = 0;
        hold_request   = 1'b0;
        hold_done      = 1'b0;
        done_seen      = 1'b0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;

        rst_n                <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= REG_PIXEL_FORMAT;
        cfg_ch.data          <= '0;
        din_ch.valid         <= 1'b0;
        din_ch.command       <= CMD_PAL_WRITE;
        din_ch.palette_index <= '0;
        din_ch.palette_color <= '0;
        din_ch.data_byte     <= '0;
        dout_ch.ready        <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: one short row per format, field extremes ---
        // 1 bpp, width 10: two data bytes then two padding bytes.
        // Height saturates (8191 -> 4096) so dest_row starts at 4095.
        write_register(REG_PIXEL_FORMAT, 13'(FMT_1BPP));
        write_register(REG_IMAGE_WIDTH, 13'd10);
        write_register(REG_IMAGE_HEIGHT, 13'h1FFF);
        cfg_ch.valid <= 1'b0;
        send_beat(CMD_PAL_WRITE, 8'd0, 24'h000000, 8'h00);
        send_beat(CMD_PAL_WRITE, 8'd1, 24'hFFFFFF, 8'hFF);
        send_beat(CMD_PAL_WRITE, 8'd15, 24'h00FF00, 8'h5A);
        send_beat(CMD_PAL_WRITE, 8'd255, 24'h800001, 8'hA5);
        send_byte(8'hFF);
        send_byte(8'h80);   // pad bits past x=9 make no pixels
        send_byte(8'hAA);   // row padding
        send_byte(8'h55);

        // 4 bpp, width 3: second byte's low nibble is past the row end
        settle();
        write_register(REG_PIXEL_FORMAT, 13'(FMT_4BPP));
        write_register(REG_IMAGE_WIDTH, 13'd3);
        cfg_ch.valid <= 1'b0;
        send_byte(8'h0F);
        send_byte(8'hF1);
        send_byte(8'h00);
        send_byte(8'hFF);

        // 8 bpp, width zero acts as one pixel
        settle();
        write_register(REG_PIXEL_FORMAT, 13'(FMT_8BPP));
        write_register(REG_IMAGE_WIDTH, 13'd0);
        cfg_ch.valid <= 1'b0;
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h7E);
        send_byte(8'h81);

        // 24 bpp BGR, width saturated; row left open for the random part
        settle();
        write_register(REG_PIXEL_FORMAT, 13'(FMT_24BPP));
        write_register(REG_IMAGE_WIDTH, 13'h1FFF);
        cfg_ch.valid <= 1'b0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h01);

        // --- random: mostly whole rows with random content, config
        // changed between bursts while counters carry over mid-row ---
        while (random_beats < RANDOM_BEATS) begin
            settle();
            if (phase_count == 4) begin
                // dense 1 bpp burst against a long output hold-off
                write_register(REG_PIXEL_FORMAT, 13'(FMT_1BPP));
                write_register(REG_IMAGE_WIDTH, 13'd64);
                cfg_ch.valid <= 1'b0;
                tx_idle_on   = 1'b0;
                hold_request = 1'b1;
                n = 24;
            end else begin
                pick = $urandom_range(0, 7);
                if (pick != 0)
                    write_register(REG_PIXEL_FORMAT, 13'($urandom_range(0, 3)));
                if (pick != 1) begin
                    case ($urandom_range(0, 9))
                        0:       dim = 13'd0;
                        1:       dim = 13'h1FFF;
                        2:       dim = 13'd4096;
                        3:       dim = 13'($urandom_range(25, 200));
                        default: dim = 13'($urandom_range(1, 24));
                    endcase
                    write_register(REG_IMAGE_WIDTH, dim);
                end
                if (pick == 1 || $urandom_range(0, 2) == 0) begin
                    // stay well clear of the last row; the image ends only once
                    case ($urandom_range(0, 2))
                        0:       dim = 13'h1FFF;
                        1:       dim = 13'd4096;
                        default: dim = 13'($urandom_range(pixel_pred.source_row + 128, 4095));
                    endcase
                    write_register(REG_IMAGE_HEIGHT, dim);
                end
                cfg_ch.valid <= 1'b0;
                tx_idle_on = ($urandom_range(0, 3) != 0);
                n = pixel_pred.bytes_left();
                if ($urandom_range(0, 1))
                    n += pixel_pred.row_len();
                // broken rows: stop short and reconfigure mid-row
                if ($urandom_range(0, 3) == 0)
                    n = $urandom_range(1, n);
                if (n > MAX_PHASE_BYTES)
                    n = MAX_PHASE_BYTES;
            end
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_palette_entry();
                    random_beats++;
                end
                send_row_byte();
                random_beats++;
            end
        end

        // --- image end: finish the open row, then a last row of the
        // image so the final pixel carries image_done ---
        settle();
        tx_idle_on = 1'b1;
        write_register(REG_PIXEL_FORMAT, 13'(FMT_1BPP));
        write_register(REG_IMAGE_WIDTH, 13'd13);
        cfg_ch.valid <= 1'b0;
        if (pixel_pred.byte_in_row != 0) begin
            n = pixel_pred.bytes_left();
            for (int i = 0; i < n; i++)
                send_row_byte();
        end
        settle();
        write_register(REG_IMAGE_HEIGHT, 13'(pixel_pred.source_row + 1));
        cfg_ch.valid <= 1'b0;
        n = pixel_pred.row_len();
        for (int i = 0; i < n; i++)
            send_row_byte();
        // trailing bytes are swallowed
        for (int i = 0; i < 4; i++)
            send_row_byte();

        // height zero after the end: still nothing comes out
        settle();
        write_register(REG_IMAGE_HEIGHT, 13'd0);
        write_register(REG_PIXEL_FORMAT, 13'(FMT_24BPP));
        cfg_ch.valid <= 1'b0;
        for (int i = 0; i < 3; i++)
            send_row_byte();
        send_palette_entry();

        settle();

        $display("run covered %0d palette writes and %0d pixel bytes over %0d settings,",
                 palette_writes, data_bytes, phase_count);
        $display("%0d pixels checked, output hold-off %0s, image end %0s",
                 pixel_pred.pixels_checked, hold_done ? "done" : "missed",
                 done_seen ? "flagged" : "not flagged");
        if (pixel_pred.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
